// ----- hw/rtl/gcd3d_pkg.sv -----
// shared types, constants and the arctangent table for the distance pipeline
// no dependencies

package gcd3d_pkg;

   localparam int TRIG_ITERATIONS_DEF = 30;

   // reduction lanes, cordic datapath and angle widths
   localparam int AW = 34;
   localparam int CW = 34;
   localparam int ZW = 33;

   localparam logic signed [AW-1:0] TURN_UNITS         = 34'sd3600000000;
   localparam logic signed [AW-1:0] HALF_TURN_UNITS    = 34'sd1800000000;
   localparam logic signed [AW-1:0] QUARTER_TURN_UNITS = 34'sd900000000;

   localparam logic [32:0] DEG_SCALE       = 33'd8048910508;
   localparam logic [CW-1:0] GAIN_INV_Q30  = 34'd652032874;
   localparam logic [ZW-1:0] HALF_PI_Q30   = 33'd1686629713;
   localparam logic [29:0] EARTH_RADIUS_CM = 30'd637100000;
   localparam logic signed [36:0] ONE_Q30  = 37'sd1073741824;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 flip;
   } rot_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
   } vec_type;

   // atan(2^-i) in q30, rounded to nearest
   function automatic logic [30:0] atan_q30(input int i);
      logic [30:0] v;
      v = '0;
      if (i < 10) begin
         unique case (i)
            0:       v = 31'd843314857;
            1:       v = 31'd497837829;
            2:       v = 31'd263043837;
            3:       v = 31'd133525159;
            4:       v = 31'd67021687;
            5:       v = 31'd33543516;
            6:       v = 31'd16775851;
            7:       v = 31'd8388437;
            8:       v = 31'd4194283;
            9:       v = 31'd2097149;
            default: v = '0;
         endcase
      end else if (i <= 30) begin
         v = 31'd1 << (30 - i);
      end else if (i == 31) begin
         v = 31'd1;
      end
      return v;
   endfunction

endpackage

// ----- hw/rtl/gcd3d_rot_cell.sv -----
// one rotation-mode cordic cell, registered output
// depends on gcd3d_pkg

module gcd3d_rot_cell
   import gcd3d_pkg::*;
#(
   parameter int SHIFT = 0
) (
   input  logic    clock,
   input  rot_type cell_in,
   output rot_type cell_out
);

   localparam logic signed [ZW-1:0] ATAN = ZW'(atan_q30(SHIFT));

   logic signed [CW-1:0] xi, yi, dx, dy;
   logic signed [ZW-1:0] zi;
   rot_type out_in, out_ff;

   always_comb begin
      xi = cell_in.x;
      yi = cell_in.y;
      zi = cell_in.z;
      dx = yi >>> SHIFT;
      dy = xi >>> SHIFT;
      out_in = cell_in;
      if (zi >= 0) begin
         out_in.x = xi - dx;
         out_in.y = yi + dy;
         out_in.z = zi - ATAN;
      end else begin
         out_in.x = xi + dx;
         out_in.y = yi - dy;
         out_in.z = zi + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign cell_out = out_ff;

endmodule

// ----- hw/rtl/gcd3d_vec_cell.sv -----
// one vectoring-mode cordic cell, registered output
// depends on gcd3d_pkg

module gcd3d_vec_cell
   import gcd3d_pkg::*;
#(
   parameter int SHIFT = 0
) (
   input  logic    clock,
   input  vec_type cell_in,
   output vec_type cell_out
);

   localparam logic signed [ZW-1:0] ATAN = ZW'(atan_q30(SHIFT));

   logic signed [CW-1:0] xi, yi, dx, dy;
   logic signed [ZW-1:0] zi;
   vec_type out_in, out_ff;

   always_comb begin
      xi = cell_in.x;
      yi = cell_in.y;
      zi = cell_in.z;
      dx = yi >>> SHIFT;
      dy = xi >>> SHIFT;
      if (yi >= 0) begin
         out_in.x = xi + dx;
         out_in.y = yi - dy;
         out_in.z = zi + ATAN;
      end else begin
         out_in.x = xi - dx;
         out_in.y = yi + dy;
         out_in.z = zi - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign cell_out = out_ff;

endmodule

// ----- hw/rtl/gcd3d_sqrt_cell.sv -----
// one digit step of a restoring integer square root, registered, with a side tag
// depends on gcd3d_pkg

module gcd3d_sqrt_cell
   import gcd3d_pkg::*;
#(
   parameter int W    = 64,
   parameter int TW   = 1,
   parameter int STEP = 0
) (
   input  logic          clock,
   input  logic [W-1:0]  in_v,
   input  logic [W-1:0]  in_r,
   input  logic [TW-1:0] in_tag,
   output logic [W-1:0]  out_v,
   output logic [W-1:0]  out_r,
   output logic [TW-1:0] out_tag
);

   localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * STEP);

   logic [W:0]    trial;
   logic [W-1:0]  v_in, v_ff, r_in, r_ff;
   logic [TW-1:0] tag_ff;

   always_comb begin
      trial = {1'b0, in_r} + {1'b0, BIT};
      if ({1'b0, in_v} >= trial) begin
         v_in = in_v - trial[W-1:0];
         r_in = (in_r >> 1) + BIT;
      end else begin
         v_in = in_v;
         r_in = in_r >> 1;
      end
   end

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      r_ff   <= r_in;
      tag_ff <= in_tag;
   end

   assign out_v   = v_ff;
   assign out_r   = r_ff;
   assign out_tag = tag_ff;

endmodule

// ----- hw/rtl/great_circle_distance_3d_top.sv -----
// distance between two positions: law-of-cosines central angle plus elevation
// depends on gcd3d_pkg, gcd3d_rot_cell, gcd3d_vec_cell, gcd3d_sqrt_cell
//
// usage
//   a transaction is taken on a rising edge with start high and busy low;
//   busy is low whenever reset is low, so a transaction can enter every cycle
//   each transaction gives one result: rsp_strobe is high for one cycle with
//   rsp_distance_cm, in the order the transactions were taken
//   throughput one transaction per cycle
//   the latency is set by the cordic rows (three rotation rows for the sines and
//   cosines, one vectoring row for the arccosine, TRIG_ITERATIONS cells each),
//   two square root rows of 31 and 32 cells, plus multiplier and reduction stages
//   the receiver cannot stall; every result is shown once and taken
//   synchronous reset drops every transaction in flight and holds busy high;
//   datapath registers are not reset
module great_circle_distance_3d_top
   import gcd3d_pkg::*;
#(
   parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [30:0] req_lat_a,
   input  logic signed [31:0] req_lon_a,
   input  logic signed [27:0] req_elev_a,
   input  logic signed [30:0] req_lat_b,
   input  logic signed [31:0] req_lon_b,
   input  logic signed [27:0] req_elev_b,
   output logic               rsp_strobe,
   output logic [31:0]        rsp_distance_cm
);

   localparam int N        = TRIG_ITERATIONS;
   localparam int LATENCY  = 77 + 2 * N;
   localparam int DH_DEPTH = 41 + 2 * N;
   localparam int S1W      = 62;
   localparam int S1N      = S1W / 2;
   localparam int S2W      = 64;
   localparam int S2N      = S2W / 2;
   localparam int SQRT1_END = 38 + N;
   localparam logic [S1W-1:0] ONE_SQ = S1W'(1) << 60;

   logic accept;
   logic [LATENCY-1:0] vld_in, vld_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   always_comb begin
      vld_in = {vld_ff[LATENCY-2:0], accept};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // input stage
   logic signed [AW-1:0] ang0_in [3];
   logic signed [AW-1:0] ang0_ff [3];
   logic signed [28:0]   dh_diff;
   logic [28:0]          dh_in;
   logic [28:0]          dh_ff [DH_DEPTH+1];

   always_comb begin
      ang0_in[0] = AW'(req_lat_a);
      ang0_in[1] = AW'(req_lat_b);
      ang0_in[2] = AW'(req_lon_a) - AW'(req_lon_b);
      dh_diff    = 29'(req_elev_a) - 29'(req_elev_b);
      dh_in      = dh_diff < 0 ? 29'(-dh_diff) : 29'(dh_diff);
   end

   always_ff @(posedge clock) begin
      ang0_ff  <= ang0_in;
      dh_ff[0] <= dh_in;
      for (int k = 1; k <= DH_DEPTH; k++) begin
         dh_ff[k] <= dh_ff[k-1];
      end
   end

   // angle reduction and conversion to radians
   logic signed [AW-1:0] r1_in [3], r1_ff [3];
   logic signed [AW-1:0] r2 [3];
   logic [29:0]          mag_in [3], mag_ff [3];
   logic                 neg_in [3], neg_ff [3], neg3_ff [3];
   logic                 flip_in [3], flip_ff [3], flip3_ff [3];
   logic [62:0]          prod_in [3], prod_ff [3];
   logic [63:0]          zsum [3];
   logic signed [ZW-1:0] zmag [3];
   rot_type              rot_ch [3][N+1];

   for (genvar l = 0; l < 3; l++) begin : g_lane
      always_comb begin
         r1_in[l] = ang0_ff[l];
         if (ang0_ff[l] >= TURN_UNITS) begin
            r1_in[l] = ang0_ff[l] - TURN_UNITS;
         end else if (ang0_ff[l] <= -TURN_UNITS) begin
            r1_in[l] = ang0_ff[l] + TURN_UNITS;
         end
         if (r1_in[l] > HALF_TURN_UNITS) begin
            r1_in[l] = r1_in[l] - TURN_UNITS;
         end else if (r1_in[l] < -HALF_TURN_UNITS) begin
            r1_in[l] = r1_in[l] + TURN_UNITS;
         end

         r2[l]      = r1_ff[l];
         flip_in[l] = 1'b0;
         if (r1_ff[l] > QUARTER_TURN_UNITS) begin
            r2[l]      = r1_ff[l] - HALF_TURN_UNITS;
            flip_in[l] = 1'b1;
         end else if (r1_ff[l] < -QUARTER_TURN_UNITS) begin
            r2[l]      = r1_ff[l] + HALF_TURN_UNITS;
            flip_in[l] = 1'b1;
         end
         neg_in[l] = r2[l] < 0;
         mag_in[l] = neg_in[l] ? 30'(-r2[l]) : 30'(r2[l]);

         prod_in[l] = 63'(mag_ff[l]) * 63'(DEG_SCALE);

         zsum[l] = 64'(prod_ff[l]) + (64'd1 << 31);
         zmag[l] = ZW'(zsum[l][63:32]);
         rot_ch[l][0].x    = GAIN_INV_Q30;
         rot_ch[l][0].y    = '0;
         rot_ch[l][0].z    = neg3_ff[l] ? -zmag[l] : zmag[l];
         rot_ch[l][0].flip = flip3_ff[l];
      end

      always_ff @(posedge clock) begin
         r1_ff[l]    <= r1_in[l];
         mag_ff[l]   <= mag_in[l];
         neg_ff[l]   <= neg_in[l];
         flip_ff[l]  <= flip_in[l];
         prod_ff[l]  <= prod_in[l];
         neg3_ff[l]  <= neg_ff[l];
         flip3_ff[l] <= flip_ff[l];
      end

      for (genvar k = 0; k < N; k++) begin : g_rot
         gcd3d_rot_cell #(
            .SHIFT(k)
         ) u_cell (
            .clock   (clock),
            .cell_in (rot_ch[l][k]),
            .cell_out(rot_ch[l][k+1])
         );
      end
   end

   // cosine sum
   logic signed [31:0] sa, sb, ca, cb, cd;
   logic signed [63:0] p1_in, p1_ff, p2_in, p2_ff;
   logic signed [31:0] cd_ff;
   logic signed [33:0] t1_in, t1_ff, p2s;
   logic signed [65:0] t2_in, t2_ff;
   logic signed [36:0] csum;
   logic signed [31:0] c_in, c_ff, c_d_ff;
   logic [S1W-1:0]     cc_in, cc_ff;

   always_comb begin
      sa = rot_ch[0][N].flip ? 32'(-rot_ch[0][N].y) : 32'(rot_ch[0][N].y);
      ca = rot_ch[0][N].flip ? 32'(-rot_ch[0][N].x) : 32'(rot_ch[0][N].x);
      sb = rot_ch[1][N].flip ? 32'(-rot_ch[1][N].y) : 32'(rot_ch[1][N].y);
      cb = rot_ch[1][N].flip ? 32'(-rot_ch[1][N].x) : 32'(rot_ch[1][N].x);
      cd = rot_ch[2][N].flip ? 32'(-rot_ch[2][N].x) : 32'(rot_ch[2][N].x);
      p1_in = 64'(sa) * 64'(sb);
      p2_in = 64'(ca) * 64'(cb);
      t1_in = 34'(p1_ff >>> 30);
      p2s   = 34'(p2_ff >>> 30);
      t2_in = 66'(p2s) * 66'(cd_ff);
      csum  = 37'(t1_ff) + 37'(t2_ff >>> 30);
      if (csum > ONE_Q30) begin
         c_in = 32'(ONE_Q30);
      end else if (csum < -ONE_Q30) begin
         c_in = 32'(-ONE_Q30);
      end else begin
         c_in = 32'(csum);
      end
      cc_in = S1W'(64'(c_ff) * 64'(c_ff));
   end

   always_ff @(posedge clock) begin
      p1_ff  <= p1_in;
      p2_ff  <= p2_in;
      cd_ff  <= cd;
      t1_ff  <= t1_in;
      t2_ff  <= t2_in;
      c_ff   <= c_in;
      cc_ff  <= cc_in;
      c_d_ff <= c_ff;
   end

   // sine of the central angle, sqrt(1 - c*c)
   logic [S1W-1:0] s1_v [S1N+1];
   logic [S1W-1:0] s1_r [S1N+1];
   logic [31:0]    s1_tag [S1N+1];

   assign s1_v[0]   = ONE_SQ - cc_ff;
   assign s1_r[0]   = '0;
   assign s1_tag[0] = c_d_ff;

   for (genvar k = 0; k < S1N; k++) begin : g_sqrt1
      gcd3d_sqrt_cell #(
         .W   (S1W),
         .TW  (32),
         .STEP(k)
      ) u_cell (
         .clock  (clock),
         .in_v   (s1_v[k]),
         .in_r   (s1_r[k]),
         .in_tag (s1_tag[k]),
         .out_v  (s1_v[k+1]),
         .out_r  (s1_r[k+1]),
         .out_tag(s1_tag[k+1])
      );
   end

   // arccosine by vectoring
   logic signed [31:0] c_s;
   logic [30:0]        s_root;
   vec_type            vec_ch [N+1];

   always_comb begin
      c_s    = s1_tag[S1N];
      s_root = s1_r[S1N][30:0];
      if (c_s < 0) begin
         vec_ch[0].x = CW'(s_root);
         vec_ch[0].y = -CW'(c_s);
         vec_ch[0].z = HALF_PI_Q30;
      end else begin
         vec_ch[0].x = CW'(c_s);
         vec_ch[0].y = CW'(s_root);
         vec_ch[0].z = '0;
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_vec
      gcd3d_vec_cell #(
         .SHIFT(k)
      ) u_cell (
         .clock   (clock),
         .cell_in (vec_ch[k]),
         .cell_out(vec_ch[k+1])
      );
   end

   // radius scaling and elevation term
   logic signed [ZW-1:0] vz;
   logic [31:0]          ang_in, ang_ff;
   logic [61:0]          hp_in, hp_ff;
   logic [62:0]          hsum;
   logic [31:0]          h_in, h_ff;
   logic [63:0]          hh_in, hh_ff;
   logic [57:0]          dd_in, dd_ff;
   logic [S2W-1:0]       sum_in, sum_ff;

   always_comb begin
      vz     = vec_ch[N].z;
      ang_in = vz < 0 ? '0 : vz[31:0];
      hp_in  = 62'(ang_ff) * 62'(EARTH_RADIUS_CM);
      hsum   = 63'(hp_ff) + (63'd1 << 29);
      h_in   = hsum[61:30];
      hh_in  = 64'(h_ff) * 64'(h_ff);
      dd_in  = 58'(dh_ff[DH_DEPTH]) * 58'(dh_ff[DH_DEPTH]);
      sum_in = hh_ff + S2W'(dd_ff);
   end

   always_ff @(posedge clock) begin
      ang_ff <= ang_in;
      hp_ff  <= hp_in;
      h_ff   <= h_in;
      hh_ff  <= hh_in;
      dd_ff  <= dd_in;
      sum_ff <= sum_in;
   end

   // straight-line distance
   logic [S2W-1:0] s2_v [S2N+1];
   logic [S2W-1:0] s2_r [S2N+1];
   logic [0:0]     s2_tag [S2N+1];
   logic [31:0]    dist_ff;

   assign s2_v[0]   = sum_ff;
   assign s2_r[0]   = '0;
   assign s2_tag[0] = 1'b0;

   for (genvar k = 0; k < S2N; k++) begin : g_sqrt2
      gcd3d_sqrt_cell #(
         .W   (S2W),
         .TW  (1),
         .STEP(k)
      ) u_cell (
         .clock  (clock),
         .in_v   (s2_v[k]),
         .in_r   (s2_r[k]),
         .in_tag (s2_tag[k]),
         .out_v  (s2_v[k+1]),
         .out_r  (s2_r[k+1]),
         .out_tag(s2_tag[k+1])
      );
   end

   always_ff @(posedge clock) begin
      dist_ff <= s2_r[S2N][31:0];
   end

   assign rsp_strobe      = vld_ff[LATENCY-1];
   assign rsp_distance_cm = dist_ff;

   // checks
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_strobe)
      else $error("transaction taken without a result after the pipeline latency");

   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LATENCY))
      else $error("result without a matching transaction");

   a_sine_in_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[SQRT1_END] |-> s_root <= (31'd1 << 30))
      else $error("sine of central angle above one");

   a_no_accept_in_reset: assert property (@(posedge clock)
      reset |=> !vld_ff[0])
      else $error("transaction entered the pipeline during reset");

endmodule
